@@ design/triangle_plane_mirror_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the triangle plane mirror
// Clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_MIRROR_ASSERT_SVH
`define TRIANGLE_PLANE_MIRROR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge
`define TPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TPM_ASSERT(label, prop, msg)
`define TPM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ design/tpm_pkg.sv @@
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared widths, fixed-point types, structs and codes of the plane mirror.
// ----------------------------------------------------------------------------
package tpm_pkg;

  // Field widths
  localparam int PosW     = 24;   // Q15.8
  localparam int NrmW     = 16;   // Q1.14
  localparam int TexW     = 32;
  localparam int OffW     = 24;   // Q15.8
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam int NrmFrac = 14;
  localparam int FracSh  = 28;    // scale of the reflection terms

  // Intermediate widths
  localparam int PpW = PosW + NrmW;     // pl * p
  localparam int PnW = 2 * NrmW;        // pl * n
  localparam int SpW = PpW + 2;         // signed distance sum
  localparam int SnW = PnW + 2;         // normal dot sum
  localparam int MpW = SpW + NrmW;      // sp * pl
  localparam int MnW = SnW + NrmW;      // sn * pl
  localparam int TpW = MpW + 3;
  localparam int TnW = MnW + 3;
  localparam int RpW = TpW - FracSh;    // rounded position before clamp
  localparam int RnW = TnW - FracSh;    // rounded normal before clamp

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic signed [NrmW-1:0] nrm_t;
  typedef logic        [TexW-1:0] tex_t;
  typedef logic signed [OffW-1:0] off_t;
  typedef logic signed [PpW-1:0]  pp_t;
  typedef logic signed [PnW-1:0]  pn_t;
  typedef logic signed [SpW-1:0]  sp_t;
  typedef logic signed [SnW-1:0]  sn_t;
  typedef logic signed [MpW-1:0]  mp_t;
  typedef logic signed [MnW-1:0]  mn_t;
  typedef logic signed [TpW-1:0]  tp_t;
  typedef logic signed [TnW-1:0]  tn_t;
  typedef logic signed [RpW-1:0]  rp_t;
  typedef logic signed [RnW-1:0]  rn_t;
  typedef logic [1:0]             corner_t;
  typedef logic [CfgIdxW-1:0]     cfg_idx_t;
  typedef logic [CfgDataW-1:0]    cfg_data_t;

  // Constants
  localparam nrm_t    NrmOne     = nrm_t'(2 ** NrmFrac);
  localparam rp_t     RpMax      = rp_t'(2 ** (PosW - 1) - 1);
  localparam rp_t     RpMin      = rp_t'(-(2 ** (PosW - 1)));
  localparam rn_t     RnMax      = rn_t'(2 ** NrmFrac);
  localparam rn_t     RnMin      = rn_t'(-(2 ** NrmFrac));
  localparam corner_t LastCorner = corner_t'(2);

  // Register indexes
  localparam cfg_idx_t RegNrmX = cfg_idx_t'(0);
  localparam cfg_idx_t RegNrmY = cfg_idx_t'(1);
  localparam cfg_idx_t RegNrmZ = cfg_idx_t'(2);
  localparam cfg_idx_t RegOff  = cfg_idx_t'(3);

  // Emit sequence of the output stage
  typedef enum logic [1:0] {
    StepPass,
    StepHeld0,
    StepMirror,
    StepHeld1
  } step_e;

  typedef struct packed {
    nrm_t [2:0] nrm;
    off_t       off;
  } plane_t;

  typedef struct packed {
    pos_t [2:0] pos;
    nrm_t [2:0] nrm;
    tex_t       u;
    tex_t       v;
    corner_t    corner;
  } vtx_t;

  // Queue entry: vertex plus its plane dot products
  typedef struct packed {
    vtx_t vtx;
    sp_t  sp;
    sn_t  sn;
  } item_t;

endpackage

@@ design/tpm_if.sv @@
// ----------------------------------------------------------------------------
// tpm channel interfaces
// Valid/ready channels for vertices in, results out and register writes.
// ----------------------------------------------------------------------------
interface tpm_vtx_if;
  logic          valid;
  logic          ready;
  tpm_pkg::pos_t pos_x;
  tpm_pkg::pos_t pos_y;
  tpm_pkg::pos_t pos_z;
  tpm_pkg::nrm_t nrm_x;
  tpm_pkg::nrm_t nrm_y;
  tpm_pkg::nrm_t nrm_z;
  tpm_pkg::tex_t tex_u;
  tpm_pkg::tex_t tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                  output ready);
endinterface

interface tpm_res_if;
  logic          valid;
  logic          ready;
  tpm_pkg::pos_t out_pos_x;
  tpm_pkg::pos_t out_pos_y;
  tpm_pkg::pos_t out_pos_z;
  tpm_pkg::nrm_t out_nrm_x;
  tpm_pkg::nrm_t out_nrm_y;
  tpm_pkg::nrm_t out_nrm_z;
  tpm_pkg::tex_t out_u;
  tpm_pkg::tex_t out_v;
  logic          last;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, out_u, out_v, last, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, out_u, out_v, last, output ready);
endinterface

interface tpm_cfg_if;
  logic               valid;
  logic               ready;
  tpm_pkg::cfg_idx_t  index;
  tpm_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/tpm_fifo.sv @@
// ----------------------------------------------------------------------------
// tpm_fifo
// Small queue of classified vertices between the front and back parts.
// ----------------------------------------------------------------------------
module tpm_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tpm_pkg::item_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output tpm_pkg::item_t  data_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tpm_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/tpm_front.sv @@
// ----------------------------------------------------------------------------
// tpm_front
// Accepts vertices, tags the triangle corner and forms the plane distance
// and normal dot products in two pipeline stages.
// ----------------------------------------------------------------------------
module tpm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpm_pkg::plane_t plane_i,
  tpm_vtx_if.sink         vtx_i,
  output logic            push_o,
  output tpm_pkg::item_t  item_o,
  input  logic            full_i
);

  logic            s1_v_q;
  tpm_pkg::vtx_t   s1_vtx_q;
  tpm_pkg::pp_t    s1_pp_q [3];
  tpm_pkg::pn_t    s1_pn_q [3];
  logic            s2_v_q;
  tpm_pkg::item_t  s2_item_q;
  tpm_pkg::corner_t cnt_q;

  tpm_pkg::pos_t   in_pos [3];
  tpm_pkg::nrm_t   in_nrm [3];
  tpm_pkg::sp_t    sp_d;
  tpm_pkg::sn_t    sn_d;
  logic            s1_ready;
  logic            s2_ready;
  logic            in_xfer;

  assign in_pos[0] = vtx_i.pos_x;
  assign in_pos[1] = vtx_i.pos_y;
  assign in_pos[2] = vtx_i.pos_z;
  assign in_nrm[0] = vtx_i.nrm_x;
  assign in_nrm[1] = vtx_i.nrm_y;
  assign in_nrm[2] = vtx_i.nrm_z;

  // stall chain
  assign push_o      = s2_v_q && !full_i;
  assign s2_ready    = !s2_v_q || !full_i;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign vtx_i.ready = s1_ready;
  assign in_xfer     = vtx_i.valid && s1_ready;
  assign item_o      = s2_item_q;

  // sums: n.p - d (scaled to Q.22) and n.v
  always_comb begin
    sp_d = tpm_pkg::sp_t'(s1_pp_q[0]) + tpm_pkg::sp_t'(s1_pp_q[1])
         + tpm_pkg::sp_t'(s1_pp_q[2])
         - (tpm_pkg::sp_t'(plane_i.off) <<< tpm_pkg::NrmFrac);
    sn_d = tpm_pkg::sn_t'(s1_pn_q[0]) + tpm_pkg::sn_t'(s1_pn_q[1])
         + tpm_pkg::sn_t'(s1_pn_q[2]);
  end

  // control: stage valids and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= vtx_i.valid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (in_xfer) begin
        cnt_q <= (cnt_q == tpm_pkg::LastCorner) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // payload: products on transfer in, sums on advance
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_vtx_q.u      <= vtx_i.tex_u;
      s1_vtx_q.v      <= vtx_i.tex_v;
      s1_vtx_q.corner <= cnt_q;
      for (int i = 0; i < 3; i++) begin
        s1_vtx_q.pos[i] <= in_pos[i];
        s1_vtx_q.nrm[i] <= in_nrm[i];
        s1_pp_q[i] <= tpm_pkg::pp_t'(in_pos[i]) * tpm_pkg::pp_t'(plane_i.nrm[i]);
        s1_pn_q[i] <= tpm_pkg::pn_t'(in_nrm[i]) * tpm_pkg::pn_t'(plane_i.nrm[i]);
      end
    end
    if (s1_v_q && s2_ready) begin
      s2_item_q.vtx <= s1_vtx_q;
      s2_item_q.sp  <= sp_d;
      s2_item_q.sn  <= sn_d;
    end
  end

endmodule

@@ design/tpm_back.sv @@
// ----------------------------------------------------------------------------
// tpm_back
// Reflects queued vertices across the plane, keeps the first two mirrored
// corners and emits pass-through plus mirrored triangle in order 0, 2, 1.
// ----------------------------------------------------------------------------
`include "triangle_plane_mirror_assert.svh"

module tpm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpm_pkg::plane_t plane_i,
  input  tpm_pkg::item_t  item_i,
  input  logic            empty_i,
  output logic            pop_o,
  tpm_res_if.source       res_o
);

  // p - 2(sp)pl, rounded half up, saturated
  function automatic tpm_pkg::pos_t reflect_pos(tpm_pkg::pos_t p, tpm_pkg::mp_t m);
    tpm_pkg::tp_t  t;
    tpm_pkg::rp_t  r;
    tpm_pkg::pos_t res;
    t = (tpm_pkg::tp_t'(p) <<< tpm_pkg::FracSh) - (tpm_pkg::tp_t'(m) <<< 1)
      + (tpm_pkg::tp_t'(1) <<< (tpm_pkg::FracSh - 1));
    r = t[tpm_pkg::TpW-1:tpm_pkg::FracSh];
    if (r > tpm_pkg::RpMax) begin
      res = tpm_pkg::pos_t'(tpm_pkg::RpMax);
    end else if (r < tpm_pkg::RpMin) begin
      res = tpm_pkg::pos_t'(tpm_pkg::RpMin);
    end else begin
      res = tpm_pkg::pos_t'(r);
    end
    return res;
  endfunction

  // v - 2(sn)pl, rounded half up, saturated
  function automatic tpm_pkg::nrm_t reflect_nrm(tpm_pkg::nrm_t n, tpm_pkg::mn_t m);
    tpm_pkg::tn_t  t;
    tpm_pkg::rn_t  r;
    tpm_pkg::nrm_t res;
    t = (tpm_pkg::tn_t'(n) <<< tpm_pkg::FracSh) - (tpm_pkg::tn_t'(m) <<< 1)
      + (tpm_pkg::tn_t'(1) <<< (tpm_pkg::FracSh - 1));
    r = t[tpm_pkg::TnW-1:tpm_pkg::FracSh];
    if (r > tpm_pkg::RnMax) begin
      res = tpm_pkg::nrm_t'(tpm_pkg::RnMax);
    end else if (r < tpm_pkg::RnMin) begin
      res = tpm_pkg::nrm_t'(tpm_pkg::RnMin);
    end else begin
      res = tpm_pkg::nrm_t'(r);
    end
    return res;
  endfunction

  // multiply stage
  logic            b1_v_q;
  tpm_pkg::vtx_t   b1_vtx_q;
  tpm_pkg::mp_t    b1_mp_q [3];
  tpm_pkg::mn_t    b1_mn_q [3];

  // output stage
  logic            ov_q;
  tpm_pkg::vtx_t   oi_q;
  tpm_pkg::pos_t   mpos_q [3];
  tpm_pkg::nrm_t   mnrm_q [3];
  tpm_pkg::step_e  step_q;
  tpm_pkg::step_e  step_d;

  // held mirrored corners 0 and 1
  tpm_pkg::pos_t   held_pos_q [2][3];
  tpm_pkg::nrm_t   held_nrm_q [2][3];
  tpm_pkg::tex_t   held_u_q [2];
  tpm_pkg::tex_t   held_v_q [2];

  logic            res_xfer;
  logic            out_done;
  logic            out_free;
  logic            b1_ready;
  logic            load;

  // stall chain
  assign res_xfer = res_o.valid && res_o.ready;
  assign out_done = res_xfer && res_o.last;
  assign out_free = !ov_q || out_done;
  assign b1_ready = !b1_v_q || out_free;
  assign load     = b1_v_q && out_free;
  assign pop_o    = !empty_i && b1_ready;

  // emit sequence: next step
  always_comb begin
    step_d = step_q;
    if (res_xfer) begin
      unique case (step_q)
        tpm_pkg::StepPass: begin
          step_d = (oi_q.corner == tpm_pkg::LastCorner) ? tpm_pkg::StepHeld0
                                                        : tpm_pkg::StepPass;
        end
        tpm_pkg::StepHeld0:  step_d = tpm_pkg::StepMirror;
        tpm_pkg::StepMirror: step_d = tpm_pkg::StepHeld1;
        tpm_pkg::StepHeld1:  step_d = tpm_pkg::StepPass;
        default:             step_d = tpm_pkg::StepPass;
      endcase
    end
  end

  // emit sequence: result select
  always_comb begin
    res_o.valid     = ov_q;
    res_o.out_pos_x = oi_q.pos[0];
    res_o.out_pos_y = oi_q.pos[1];
    res_o.out_pos_z = oi_q.pos[2];
    res_o.out_nrm_x = oi_q.nrm[0];
    res_o.out_nrm_y = oi_q.nrm[1];
    res_o.out_nrm_z = oi_q.nrm[2];
    res_o.out_u     = oi_q.u;
    res_o.out_v     = oi_q.v;
    res_o.last      = (oi_q.corner != tpm_pkg::LastCorner);
    unique case (step_q)
      tpm_pkg::StepPass: ;
      tpm_pkg::StepHeld0: begin
        res_o.out_pos_x = held_pos_q[0][0];
        res_o.out_pos_y = held_pos_q[0][1];
        res_o.out_pos_z = held_pos_q[0][2];
        res_o.out_nrm_x = held_nrm_q[0][0];
        res_o.out_nrm_y = held_nrm_q[0][1];
        res_o.out_nrm_z = held_nrm_q[0][2];
        res_o.out_u     = held_u_q[0];
        res_o.out_v     = held_v_q[0];
        res_o.last      = 1'b0;
      end
      tpm_pkg::StepMirror: begin
        res_o.out_pos_x = mpos_q[0];
        res_o.out_pos_y = mpos_q[1];
        res_o.out_pos_z = mpos_q[2];
        res_o.out_nrm_x = mnrm_q[0];
        res_o.out_nrm_y = mnrm_q[1];
        res_o.out_nrm_z = mnrm_q[2];
        res_o.last      = 1'b0;
      end
      tpm_pkg::StepHeld1: begin
        res_o.out_pos_x = held_pos_q[1][0];
        res_o.out_pos_y = held_pos_q[1][1];
        res_o.out_pos_z = held_pos_q[1][2];
        res_o.out_nrm_x = held_nrm_q[1][0];
        res_o.out_nrm_y = held_nrm_q[1][1];
        res_o.out_nrm_z = held_nrm_q[1][2];
        res_o.out_u     = held_u_q[1];
        res_o.out_v     = held_v_q[1];
        res_o.last      = 1'b1;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      ov_q   <= 1'b0;
      step_q <= tpm_pkg::StepPass;
    end else begin
      if (b1_ready) begin
        b1_v_q <= !empty_i;
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_done) begin
        ov_q <= 1'b0;
      end
      step_q <= step_d;
    end
  end

  // payload: products, reflection, held corners
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_vtx_q <= item_i.vtx;
      for (int i = 0; i < 3; i++) begin
        b1_mp_q[i] <= tpm_pkg::mp_t'(item_i.sp) * tpm_pkg::mp_t'(plane_i.nrm[i]);
        b1_mn_q[i] <= tpm_pkg::mn_t'(item_i.sn) * tpm_pkg::mn_t'(plane_i.nrm[i]);
      end
    end
    if (load) begin
      oi_q <= b1_vtx_q;
      for (int i = 0; i < 3; i++) begin
        mpos_q[i] <= reflect_pos(b1_vtx_q.pos[i], b1_mp_q[i]);
        mnrm_q[i] <= reflect_nrm(b1_vtx_q.nrm[i], b1_mn_q[i]);
      end
      if (b1_vtx_q.corner != tpm_pkg::LastCorner) begin
        for (int i = 0; i < 3; i++) begin
          held_pos_q[b1_vtx_q.corner[0]][i] <= reflect_pos(b1_vtx_q.pos[i], b1_mp_q[i]);
          held_nrm_q[b1_vtx_q.corner[0]][i] <= reflect_nrm(b1_vtx_q.nrm[i], b1_mn_q[i]);
        end
        held_u_q[b1_vtx_q.corner[0]] <= b1_vtx_q.u;
        held_v_q[b1_vtx_q.corner[0]] <= b1_vtx_q.v;
      end
    end
  end

  // checks
  `TPM_ASSERT(a_single_result_corner, ov_q && (oi_q.corner != tpm_pkg::LastCorner) |-> step_q == tpm_pkg::StepPass, "mirror sequence started on a first or second corner")
  `TPM_ASSERT_NEXT(a_last_rearms, res_o.valid && res_o.ready && res_o.last, step_q == tpm_pkg::StepPass, "emit step not rearmed after last result")
  `TPM_ASSERT(a_corner_range, b1_v_q |-> b1_vtx_q.corner <= tpm_pkg::LastCorner, "corner tag out of range")

endmodule

@@ design/triangle_plane_mirror.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_mirror
// Passes triangle vertices through and appends each triangle mirrored across
// a configured plane, with its winding flipped.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  vtx_i    in   valid / ready  pos_x..z, nrm_x..z, tex_u, tex_v
//  res_o    out  valid / ready  out_pos_x..z, out_nrm_x..z, out_u, out_v, last
//  cfg_i    in   valid / ready  index, data (ready is always high)
//
//  A vertex passes front stages s1 and s2, the queue, multiply stage b1 and
//  the output stage before its first result is shown. Three vertices give
//  six results, one per cycle while res_o.ready is high; res_o sets the rate.
//  Reset clears control and loads the plane registers; held corners are not
//  cleared. A stall on res_o backs up through the queue to vtx_i.ready.
// ----------------------------------------------------------------------------
module triangle_plane_mirror #(
  parameter int QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpm_vtx_if.sink   vtx_i,
  tpm_res_if.source res_o,
  tpm_cfg_if.sink   cfg_i
);

  tpm_pkg::plane_t plane_q;
  tpm_pkg::item_t  push_item;
  tpm_pkg::item_t  pop_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nrm[0] <= tpm_pkg::NrmOne;
      plane_q.nrm[1] <= '0;
      plane_q.nrm[2] <= '0;
      plane_q.off    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tpm_pkg::RegNrmX: plane_q.nrm[0] <= cfg_i.data[tpm_pkg::NrmW-1:0];
        tpm_pkg::RegNrmY: plane_q.nrm[1] <= cfg_i.data[tpm_pkg::NrmW-1:0];
        tpm_pkg::RegNrmZ: plane_q.nrm[2] <= cfg_i.data[tpm_pkg::NrmW-1:0];
        tpm_pkg::RegOff:  plane_q.off    <= cfg_i.data[tpm_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  // front: accept, tag corner, dot products
  tpm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .plane_i (plane_q),
    .vtx_i   (vtx_i),
    .push_o  (push),
    .item_o  (push_item),
    .full_i  (full)
  );

  // queue between front and back
  tpm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_item),
    .empty_o (empty)
  );

  // back: reflect and emit
  tpm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .plane_i (plane_q),
    .item_i  (pop_item),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
